FILE: design/grlm_pkg.sv
// Shared types and constants for the grid local minimum risk sum core.
// Used by every module of the block; depends on nothing else.

package grlm_pkg;

   localparam int HEIGHT_W = 4;
   localparam int SIZE_W = 8;
   localparam int RISK_W = 18;
   localparam int LOW_W = 15;
   localparam int CSR_INDEX_W = 1;

   localparam int MAX_COLUMNS_DEFAULT = 128;
   localparam int MAX_ROWS_DEFAULT = 128;

   localparam logic [SIZE_W-1:0] GRID_WIDTH_RESET = SIZE_W'(128);
   localparam logic [SIZE_W-1:0] GRID_HEIGHT_RESET = SIZE_W'(128);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic pending;
      logic [HEIGHT_W-1:0] height;
   } entry_type;

   typedef struct packed {
      logic en;
      entry_type data;
   } wr_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic first_col;
      logic first_row;
      logic last_col;
      logic last_row;
   } stage_type;

endpackage

FILE: design/grlm_line_buffer.sv
// Previous-row line buffer: one memory, a one-entry write holding register and read forwarding.
// Depends on grlm_pkg.

module grlm_line_buffer #(
   parameter int DEPTH = grlm_pkg::MAX_COLUMNS_DEFAULT,
   localparam int AddrW = $clog2(DEPTH)
) (
   input logic clock,
   input logic reset,
   input logic rd_en,
   input logic [AddrW-1:0] rd_addr,
   input logic [AddrW-1:0] wr_col,
   input grlm_pkg::wr_type left_wr,
   input grlm_pkg::wr_type last_wr,
   output grlm_pkg::entry_type rd_data
);

   grlm_pkg::entry_type mem [DEPTH];

   logic hold_vld_ff;
   logic hold_vld_in;
   logic [AddrW-1:0] hold_addr_ff;
   grlm_pkg::entry_type hold_data_ff;

   logic port_en;
   logic [AddrW-1:0] port_addr;
   grlm_pkg::entry_type port_data;
   logic [AddrW-1:0] left_addr;

   grlm_pkg::entry_type mem_q_ff;
   logic fwd_hit_ff;
   logic fwd_hit_in;
   grlm_pkg::entry_type fwd_data_ff;
   grlm_pkg::entry_type fwd_data_in;

   assign left_addr = wr_col - AddrW'(1);

   always_comb begin
      port_en = 1'b0;
      port_addr = hold_addr_ff;
      port_data = hold_data_ff;
      priority if (left_wr.en) begin
         port_en = 1'b1;
         port_addr = left_addr;
         port_data = left_wr.data;
      end else if (hold_vld_ff) begin
         port_en = 1'b1;
      end else begin
         port_en = 1'b0;
      end
   end

   always_comb begin
      hold_vld_in = hold_vld_ff;
      if (last_wr.en) begin
         hold_vld_in = 1'b1;
      end else if (!left_wr.en) begin
         hold_vld_in = 1'b0;
      end
   end

   always_comb begin
      fwd_hit_in = 1'b1;
      fwd_data_in = hold_data_ff;
      priority if (last_wr.en && (wr_col == rd_addr)) begin
         fwd_data_in = last_wr.data;
      end else if (left_wr.en && (left_addr == rd_addr)) begin
         fwd_data_in = left_wr.data;
      end else if (hold_vld_ff && (hold_addr_ff == rd_addr)) begin
         fwd_data_in = hold_data_ff;
      end else begin
         fwd_hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_wr.en) begin
         hold_addr_ff <= wr_col;
         hold_data_ff <= last_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (port_en) begin
         mem[port_addr] <= port_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         fwd_hit_ff <= fwd_hit_in;
         fwd_data_ff <= fwd_data_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : mem_q_ff;

`ifndef NO_ASSERTIONS
   // A held last-column entry is always written out before any left write; column-zero beats make none.
   a_hold_no_left_write: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> !left_wr.en)
      else $error("line buffer hold register meets a left write");
   a_hold_drains: assert property (@(posedge clock) disable iff (reset)
      (hold_vld_ff && !last_wr.en) |=> !hold_vld_ff)
      else $error("line buffer hold register not drained");
`endif

endmodule

FILE: design/grlm_verdict.sv
// Low point verdicts for one cell: compares against the cell above and to the left,
// settles pending flags, and keeps the frame totals. Depends on grlm_pkg.

module grlm_verdict (
   input logic clock,
   input logic reset,
   input logic fire,
   input grlm_pkg::stage_type stage,
   input grlm_pkg::entry_type above,
   output grlm_pkg::wr_type left_wr,
   output grlm_pkg::wr_type last_wr,
   output logic emit,
   output logic [grlm_pkg::RISK_W-1:0] risk_sum,
   output logic [grlm_pkg::LOW_W-1:0] low_point_count
);

   localparam int AddW = grlm_pkg::HEIGHT_W + 2;

   grlm_pkg::entry_type left_ff;
   grlm_pkg::entry_type left_in;
   logic [grlm_pkg::RISK_W-1:0] risk_ff;
   logic [grlm_pkg::LOW_W-1:0] low_ff;

   logic cur;
   logic left_pending;
   logic cnt_above;
   logic cnt_left;
   logic cnt_cur;
   logic [AddW-1:0] risk_add;
   logic [1:0] low_add;

   always_comb begin
      cur = 1'b1;
      cnt_above = 1'b0;
      left_pending = 1'b0;
      if (!stage.first_row) begin
         if (stage.height >= above.height) begin
            cur = 1'b0;
         end
         cnt_above = above.pending && (above.height < stage.height);
      end
      if (!stage.first_col) begin
         if (stage.height >= left_ff.height) begin
            cur = 1'b0;
         end
         left_pending = left_ff.pending && (left_ff.height < stage.height);
      end
      cnt_left = stage.last_row && left_pending;
      cnt_cur = stage.last_row && stage.last_col && cur;
   end

   always_comb begin
      risk_add = '0;
      if (cnt_above) begin
         risk_add = risk_add + AddW'(above.height) + AddW'(1);
      end
      if (cnt_left) begin
         risk_add = risk_add + AddW'(left_ff.height) + AddW'(1);
      end
      if (cnt_cur) begin
         risk_add = risk_add + AddW'(stage.height) + AddW'(1);
      end
      low_add = 2'(cnt_above) + 2'(cnt_left) + 2'(cnt_cur);
   end

   assign risk_sum = risk_ff + grlm_pkg::RISK_W'(risk_add);
   assign low_point_count = low_ff + grlm_pkg::LOW_W'(low_add);
   assign emit = stage.last_col && stage.last_row;

   assign left_wr.en = fire && !stage.first_col && !stage.last_row;
   assign left_wr.data = '{pending: left_pending, height: left_ff.height};
   assign last_wr.en = fire && stage.last_col && !stage.last_row;
   assign last_wr.data = '{pending: cur, height: stage.height};

   always_comb begin
      left_in = left_ff;
      if (emit) begin
         left_in = '0;
      end else if (!stage.last_col) begin
         left_in = '{pending: cur, height: stage.height};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         risk_ff <= '0;
         low_ff <= '0;
      end else if (fire) begin
         left_ff <= left_in;
         if (emit) begin
            risk_ff <= '0;
            low_ff <= '0;
         end else begin
            risk_ff <= risk_sum;
            low_ff <= low_point_count;
         end
      end
   end

endmodule

FILE: design/grid_local_minimum_risk_sum_core.sv
// Top level of the grid local minimum risk sum core: size registers, raster position,
// the cell stage register and the result register. Depends on grlm_pkg,
// grlm_line_buffer and grlm_verdict.
//
// Height digits enter one beat per cell on the req_ channel in raster order,
// grid_width cells per row and grid_height rows per frame (0 acts as 1, values
// above the maximum saturate). A cell is a low point when it is strictly lower
// than each of its existing four neighbours. The csr_ port writes the two size
// registers, which are to be changed by the user only while the block is idle;
// the block itself does not enforce this. One cell beat is accepted in every
// cycle while req_stall is low. Each beat is registered together with the line
// buffer read of its column, its verdicts are worked out from that stage register,
// and a frame's result is registered again before it appears on the rsp_ channel.
// Only the last cell of a frame gives a beat, carrying the risk sum and low point
// count; the totals then start again from zero. While a result waits under
// rsp_stall, further cells keep flowing; req_stall rises only when a frame's last
// cell meets a result that is still waiting. Reset clears the position, totals
// and valid flags and sets both sizes to 128; the line buffer needs no clearing.

module grid_local_minimum_risk_sum_core #(
   parameter int MAX_COLUMNS = grlm_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS = grlm_pkg::MAX_ROWS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [grlm_pkg::HEIGHT_W-1:0] req_cell_height,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [grlm_pkg::RISK_W-1:0] rsp_risk_sum,
   output logic [grlm_pkg::LOW_W-1:0] rsp_low_point_count,
   input logic csr_wr_en,
   input logic [grlm_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [grlm_pkg::SIZE_W-1:0] csr_wdata
);

   localparam int ColW = $clog2(MAX_COLUMNS);
   localparam int RowW = $clog2(MAX_ROWS);
   localparam int ColCmpW = ((ColW > grlm_pkg::SIZE_W) ? ColW : grlm_pkg::SIZE_W) + 1;
   localparam int RowCmpW = ((RowW > grlm_pkg::SIZE_W) ? RowW : grlm_pkg::SIZE_W) + 1;

   logic [grlm_pkg::SIZE_W-1:0] grid_width_ff;
   logic [grlm_pkg::SIZE_W-1:0] grid_height_ff;
   logic [grlm_pkg::SIZE_W-1:0] width_eff;
   logic [grlm_pkg::SIZE_W-1:0] height_eff;

   logic [ColW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic last_col;
   logic last_row;

   logic req_accept;
   logic s_vld_ff;
   grlm_pkg::stage_type s_ff;
   logic [ColW-1:0] s_col_ff;
   logic s_done;
   logic emit;

   grlm_pkg::entry_type above;
   grlm_pkg::wr_type left_wr;
   grlm_pkg::wr_type last_wr;
   logic [grlm_pkg::RISK_W-1:0] risk_sum;
   logic [grlm_pkg::LOW_W-1:0] low_point_count;

   logic rsp_vld_ff;
   logic [grlm_pkg::RISK_W-1:0] rsp_risk_ff;
   logic [grlm_pkg::LOW_W-1:0] rsp_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= grlm_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= grlm_pkg::GRID_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (grlm_pkg::csr_index_type'(csr_index))
            grlm_pkg::CSR_GRID_WIDTH: grid_width_ff <= csr_wdata;
            grlm_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
         endcase
      end
   end

   assign width_eff = (grid_width_ff == '0) ? grlm_pkg::SIZE_W'(1) : grid_width_ff;
   assign height_eff = (grid_height_ff == '0) ? grlm_pkg::SIZE_W'(1) : grid_height_ff;

   assign last_col = ((ColCmpW'(col_ff) + ColCmpW'(1)) >= ColCmpW'(width_eff))
      || (col_ff == ColW'(MAX_COLUMNS - 1));
   assign last_row = ((RowCmpW'(row_ff) + RowCmpW'(1)) >= RowCmpW'(height_eff))
      || (row_ff == RowW'(MAX_ROWS - 1));

   assign s_done = s_vld_ff && !(emit && rsp_vld_ff && rsp_stall);
   assign req_stall = s_vld_ff && !s_done;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + RowW'(1);
         end else begin
            col_ff <= col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (req_accept) begin
         s_vld_ff <= 1'b1;
      end else if (s_done) begin
         s_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s_ff <= '{height: req_cell_height, first_col: (col_ff == '0),
                   first_row: (row_ff == '0), last_col: last_col, last_row: last_row};
         s_col_ff <= col_ff;
      end
   end

   grlm_line_buffer #(
      .DEPTH(MAX_COLUMNS)
   ) u_line_buffer (
      .clock(clock),
      .reset(reset),
      .rd_en(req_accept),
      .rd_addr(col_ff),
      .wr_col(s_col_ff),
      .left_wr(left_wr),
      .last_wr(last_wr),
      .rd_data(above)
   );

   grlm_verdict u_verdict (
      .clock(clock),
      .reset(reset),
      .fire(s_done),
      .stage(s_ff),
      .above(above),
      .left_wr(left_wr),
      .last_wr(last_wr),
      .emit(emit),
      .risk_sum(risk_sum),
      .low_point_count(low_point_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s_done && emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s_done && emit) begin
         rsp_risk_ff <= risk_sum;
         rsp_low_ff <= low_point_count;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_risk_sum = rsp_risk_ff;
   assign rsp_low_point_count = rsp_low_ff;

`ifndef NO_ASSERTIONS
   a_result_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s_done && emit))
      else $error("result beat without a frame end");
   a_row_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_col) |=> (col_ff == '0))
      else $error("column position not cleared after the last column");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s_vld_ff && !s_done) |=> (s_vld_ff && $stable(s_ff) && $stable(s_col_ff)))
      else $error("blocked cell stage changed");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for grid_local_minimum_risk_sum_core: streams height maps and
// predicts each frame's risk sum and low point count, checking every result beat.
// Depends on grlm_pkg and the core itself.

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_COLS = grlm_pkg::MAX_COLUMNS_DEFAULT;
   localparam int unsigned MAX_ROWS = grlm_pkg::MAX_ROWS_DEFAULT;
   localparam int unsigned RANDOM_CELLS = 600;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   localparam logic [grlm_pkg::HEIGHT_W-1:0] TWO_FRAMES [18] = '{
      4'd5, 4'd5, 4'd5, 4'd5, 4'd2, 4'd5, 4'd5, 4'd5, 4'd5,
      4'd0, 4'd9, 4'd1, 4'd9, 4'd9, 4'd9, 4'd2, 4'd9, 4'd15};

   typedef struct packed {
      logic [grlm_pkg::RISK_W-1:0] risk;
      logic [grlm_pkg::LOW_W-1:0] lows;
   } frame_total_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [grlm_pkg::HEIGHT_W-1:0] req_cell_height = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [grlm_pkg::RISK_W-1:0] rsp_risk_sum;
   logic [grlm_pkg::LOW_W-1:0] rsp_low_point_count;
   logic csr_wr_en = 1'b0;
   logic [grlm_pkg::CSR_INDEX_W-1:0] csr_index = grlm_pkg::CSR_GRID_WIDTH;
   logic [grlm_pkg::SIZE_W-1:0] csr_wdata = '0;

   logic [grlm_pkg::HEIGHT_W-1:0] pending_heights[$];
   frame_total_type frame_totals[$];
   logic req_taken = 1'b0;
   int unsigned idle_pct = 18;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned pushed = 0;

   // Sizes and raster position as seen by the stimulus generator.
   int unsigned gen_w = MAX_COLS;
   int unsigned gen_h = MAX_ROWS;
   int unsigned gen_col = 0;
   int unsigned gen_row = 0;

   // Predictor state.
   logic [grlm_pkg::SIZE_W-1:0] width_reg = grlm_pkg::GRID_WIDTH_RESET;
   logic [grlm_pkg::SIZE_W-1:0] height_reg = grlm_pkg::GRID_HEIGHT_RESET;
   logic [grlm_pkg::HEIGHT_W-1:0] above_h[MAX_COLS];
   bit above_p[MAX_COLS];
   logic [grlm_pkg::HEIGHT_W-1:0] left_h = '0;
   bit left_p = 1'b0;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   logic [grlm_pkg::RISK_W-1:0] risk_acc = '0;
   logic [grlm_pkg::LOW_W-1:0] low_acc = '0;

   grid_local_minimum_risk_sum_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cell_height(req_cell_height),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_risk_sum(rsp_risk_sum),
      .rsp_low_point_count(rsp_low_point_count),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned clamp_size(logic [grlm_pkg::SIZE_W-1:0] v,
                                              int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic add_low_point(logic [grlm_pkg::HEIGHT_W-1:0] h);
      risk_acc = risk_acc + grlm_pkg::RISK_W'(h) + grlm_pkg::RISK_W'(1);
      low_acc = low_acc + grlm_pkg::LOW_W'(1);
   endtask

   task automatic score_cell(logic [grlm_pkg::HEIGHT_W-1:0] h);
      int unsigned w, rows, col;
      bit last_col, last_row, low_here, left_low;
      logic [grlm_pkg::HEIGHT_W-1:0] above;
      frame_total_type done;
      w = clamp_size(width_reg, MAX_COLS);
      rows = clamp_size(height_reg, MAX_ROWS);
      col = col_pos;
      last_col = (col + 1 >= w) || (col + 1 >= MAX_COLS);
      last_row = (row_pos + 1 >= rows);
      low_here = 1'b1;
      if (col >= MAX_COLS) col = MAX_COLS - 1;
      if (row_pos > 0) begin
         above = above_h[col];
         if (h >= above) low_here = 1'b0;
         if (above_p[col] && above < h) add_low_point(above);
      end
      if (col > 0) begin
         left_low = left_p;
         if (h >= left_h) low_here = 1'b0;
         if (left_h >= h) left_low = 1'b0;
         if (last_row) begin
            if (left_low) add_low_point(left_h);
         end else begin
            above_h[col - 1] = left_h;
            above_p[col - 1] = left_low;
         end
      end
      if (last_col) begin
         if (last_row) begin
            if (low_here) add_low_point(h);
         end else begin
            above_h[col] = h;
            above_p[col] = low_here;
         end
         col_pos = 0;
         if (last_row) begin
            done.risk = risk_acc;
            done.lows = low_acc;
            frame_totals = {frame_totals, done};
            risk_acc = '0;
            low_acc = '0;
            row_pos = 0;
            left_h = '0;
            left_p = 1'b0;
         end else begin
            row_pos++;
         end
      end else begin
         left_h = h;
         left_p = low_here;
         col_pos = col + 1;
      end
   endtask

   task automatic check_total();
      frame_total_type want;
      if (frame_totals.size() == 0) begin
         report_mismatch($sformatf("unexpected result beat: risk %0d, lows %0d",
                                   rsp_risk_sum, rsp_low_point_count));
      end else begin
         want = frame_totals.pop_front();
         if (rsp_risk_sum !== want.risk)
            report_mismatch($sformatf("risk_sum %0d, expected %0d", rsp_risk_sum, want.risk));
         if (rsp_low_point_count !== want.lows)
            report_mismatch($sformatf("low_point_count %0d, expected %0d",
                                      rsp_low_point_count, want.lows));
      end
   endtask

   task automatic queue_cell(logic [grlm_pkg::HEIGHT_W-1:0] h);
      pending_heights = {pending_heights, h};
      pushed++;
      if (gen_col + 1 >= gen_w) begin
         gen_col = 0;
         gen_row = (gen_row + 1 >= gen_h) ? 0 : gen_row + 1;
      end else begin
         gen_col++;
      end
   endtask

   task automatic wait_idle();
      while (pending_heights.size() != 0 || req_valid || frame_totals.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(grlm_pkg::csr_index_type idx, logic [grlm_pkg::SIZE_W-1:0] v);
      csr_index <= idx;
      csr_wdata <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      if (idx == grlm_pkg::CSR_GRID_WIDTH) gen_w = clamp_size(v, MAX_COLS);
      else gen_h = clamp_size(v, MAX_ROWS);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
      if (!req_valid || req_taken) begin
         if (pending_heights.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_cell_height <= pending_heights.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == grlm_pkg::CSR_GRID_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) check_total();
         if (req_valid && !req_stall) score_cell(req_cell_height);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int unsigned start, pick, w_sel, h_sel, frames, n, top, spread, base;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Tall frame at the reset height, then both sizes saturating.
      write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(1));
      repeat (128) queue_cell(grlm_pkg::HEIGHT_W'($urandom_range(0, 15)));
      wait_idle();
      write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(255));
      write_size(grlm_pkg::CSR_GRID_HEIGHT, grlm_pkg::SIZE_W'(2));
      repeat (256) queue_cell(grlm_pkg::HEIGHT_W'($urandom_range(0, 9)));
      wait_idle();
      write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(2));
      write_size(grlm_pkg::CSR_GRID_HEIGHT, grlm_pkg::SIZE_W'(129));
      repeat (256) queue_cell(grlm_pkg::HEIGHT_W'($urandom_range(0, 9)));

      // Lone cells with zero sizes, then hand-made three by three frames.
      wait_idle();
      write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(0));
      write_size(grlm_pkg::CSR_GRID_HEIGHT, grlm_pkg::SIZE_W'(0));
      queue_cell(grlm_pkg::HEIGHT_W'(0));
      queue_cell(grlm_pkg::HEIGHT_W'(9));
      queue_cell(grlm_pkg::HEIGHT_W'(15));
      wait_idle();
      write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(3));
      write_size(grlm_pkg::CSR_GRID_HEIGHT, grlm_pkg::SIZE_W'(3));
      foreach (TWO_FRAMES[i]) queue_cell(TWO_FRAMES[i]);
      queue_cell(grlm_pkg::HEIGHT_W'(4));
      queue_cell(grlm_pkg::HEIGHT_W'(3));
      queue_cell(grlm_pkg::HEIGHT_W'(8));
      queue_cell(grlm_pkg::HEIGHT_W'(1));

      // The frame is left open and both sizes shrink; the width falls beneath its position.
      wait_idle();
      write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(1));
      write_size(grlm_pkg::CSR_GRID_HEIGHT, grlm_pkg::SIZE_W'(2));
      queue_cell(grlm_pkg::HEIGHT_W'(0));
      queue_cell(grlm_pkg::HEIGHT_W'(7));
      queue_cell(grlm_pkg::HEIGHT_W'(6));

      start = pushed;
      while (pushed - start < RANDOM_CELLS) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            w_sel = $urandom_range(128, 255);
            h_sel = $urandom_range(0, 3);
         end else if (pick < 10) begin
            w_sel = $urandom_range(0, 3);
            h_sel = $urandom_range(100, 255);
         end else begin
            w_sel = $urandom_range(0, 8);
            h_sel = $urandom_range(0, 8);
         end
         // Widening an open frame would read line buffer entries never written.
         if ((gen_col != 0 || gen_row != 0)
             && clamp_size(grlm_pkg::SIZE_W'(w_sel), MAX_COLS) > gen_w)
            w_sel = $urandom_range(0, gen_w);
         wait_idle();
         idle_pct = (pushed - start >= 200 && pushed - start < 450) ? 0 : 18;
         write_size(grlm_pkg::CSR_GRID_WIDTH, grlm_pkg::SIZE_W'(w_sel));
         write_size(grlm_pkg::CSR_GRID_HEIGHT, grlm_pkg::SIZE_W'(h_sel));
         frames = (gen_w * gen_h > 64) ? 1 : $urandom_range(1, 3);
         n = frames * gen_w * gen_h;
         if ($urandom_range(3) == 0) n += $urandom_range(1, gen_w * gen_h);
         top = ($urandom_range(9) == 0) ? 15 : 9;
         spread = $urandom_range(0, top);
         base = $urandom_range(0, top - spread);
         repeat (n) queue_cell(grlm_pkg::HEIGHT_W'(base + $urandom_range(0, spread)));
      end

      wait_idle();
      repeat (4) @(negedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/grlm_pkg.sv
design/grlm_line_buffer.sv
design/grlm_verdict.sv
design/grid_local_minimum_risk_sum_core.sv
tb/sv/testbench.sv
